>>> sv/ss_pkg.sv
// shared types and constants for the stride scheduler
package ss_pkg;

  localparam int NUM_SLOTS = 64;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_PICK = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  localparam logic [31:0] BIG_STEP = 32'h7FFF_FFFF;

  // one slot table entry
  typedef struct packed {
    logic [31:0] stride;
    logic [15:0] prio;
    logic [7:0]  slice;
    logic        queued;
  } entry_t;

endpackage

>>> sv/stride_scheduler_core.sv
// stride scheduler: slot table in a synchronous memory with a sequencer around it
//
// Request channel (req_valid_i/req_stall_o) carries req_type_i, slot_i and
// priority_req_i. Every request gives exactly one result beat on the result
// channel (res_valid_o/res_stall_i): picked_valid_o, picked_slot_o,
// need_resched_o and queued_count_o.
// Enqueue, dequeue and tick do one read, modify and write of the slot entry.
// Pick scans every slot through the memory read port, one slot a cycle; if
// a queued slot is found and its priority is not zero, it then runs a
// 32-step restoring divider for the stride increment.
// One request is in flight at a time; req_stall_o is high while it is worked
// on or while its result waits, so a stall on the result side holds the block.
// Reset clears the queued count at once; the table entries, queued flags
// included, are cleared by a pass over all NUM_SLOTS slots after reset,
// during which no request is accepted. The slice limit is written through
// cfg_we_i/cfg_wdata_i and resets to 5.
module stride_scheduler_core
  import ss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       req_valid_i,
  output logic       req_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [5:0] slot_i,
  input  logic [15:0] priority_req_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       picked_valid_o,
  output logic [5:0] picked_slot_o,
  output logic       need_resched_o,
  output logic [6:0] queued_count_o
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_MOD   = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_SLAST = 4'd5;
  localparam logic [3:0] ST_PRD   = 4'd6;
  localparam logic [3:0] ST_PLOAD = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_PWR   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  entry_t mem_q [NUM_SLOTS];
  entry_t rdata_q;
  logic   we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata;

  logic [CW-1:0] count_q;
  logic [7:0]  max_slice_q;
  logic [3:0]  state_q;
  logic [1:0]  type_q;
  logic [5:0]  slot_q;
  logic [15:0] prio_q;
  logic        inr_q;
  logic [AW-1:0] idx_q;
  logic [AW-1:0] best_q;
  logic          found_q;
  logic [31:0]   beststr_q;
  logic          pv_q, rs_q;
  logic [5:0]    ps_q;
  logic [31:0]   quo_q;
  logic [15:0]   rem_q;
  logic [15:0]   divs_q;
  logic [5:0]    dcnt_q;
  entry_t        pent_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  // scan compare: sample of slot idx_q-1 appears in rdata_q
  logic [AW-1:0] prev_idx;
  logic [31:0]   diff;
  logic          take;
  assign prev_idx = idx_q - AW'(1);
  assign diff     = rdata_q.stride - beststr_q;
  assign take     = rdata_q.queued && (!found_q || diff[31]);

  logic [16:0] rtrial;
  logic [16:0] rsub;
  assign rtrial = {rem_q, quo_q[31]};
  assign rsub   = rtrial - {1'b0, divs_q};

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = '0;
    raddr = idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_IDLE: raddr = slot_i[AW-1:0];
      ST_RD: raddr = slot_q[AW-1:0];
      ST_MOD: begin
        waddr = slot_q[AW-1:0];
        wdata = rdata_q;
        if (inr_q) begin
          if (type_q == REQ_ENQ && !rdata_q.queued) begin
            we = 1'b1;
            wdata.queued = 1'b1;
            wdata.prio = prio_q;
            if (rdata_q.slice == 8'd0 || rdata_q.slice > max_slice_q)
              wdata.slice = max_slice_q;
          end else if (type_q == REQ_DEQ && rdata_q.queued) begin
            we = 1'b1;
            wdata.queued = 1'b0;
          end else if (type_q == REQ_TICK && rdata_q.slice != 8'd0) begin
            we = 1'b1;
            wdata.slice = rdata_q.slice - 8'd1;
          end
        end
      end
      ST_PRD: raddr = best_q;
      ST_PWR: begin
        we    = 1'b1;
        waddr = best_q;
        wdata = pent_q;
        wdata.stride = pent_q.stride + quo_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      count_q     <= '0;
      max_slice_q <= 8'd5;
      idx_q       <= '0;
      found_q     <= 1'b0;
      pv_q        <= 1'b0;
      rs_q        <= 1'b0;
      ps_q        <= '0;
    end else begin
      if (cfg_we_i) max_slice_q <= cfg_wdata_i;
      unique case (state_q)
        ST_CLEAR: begin
          idx_q <= idx_q + AW'(1);
          if (idx_q == AW'(NUM_SLOTS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_valid_i) begin
            type_q <= req_type_i;
            slot_q <= slot_i;
            prio_q <= priority_req_i;
            inr_q  <= (32'(slot_i) < NUM_SLOTS);
            pv_q <= 1'b0;
            ps_q <= '0;
            rs_q <= 1'b0;
            idx_q   <= '0;
            found_q <= 1'b0;
            if (req_type_i == REQ_PICK) state_q <= ST_SCAN;
            else state_q <= ST_RD;
          end
        end
        ST_RD: state_q <= ST_MOD;
        ST_MOD: begin
          state_q <= ST_OUT;
          if (inr_q) begin
            unique case (type_q)
              REQ_ENQ: if (!rdata_q.queued) count_q <= count_q + CW'(1);
              REQ_DEQ: if (rdata_q.queued) count_q <= count_q - CW'(1);
              REQ_TICK: rs_q <= (rdata_q.slice <= 8'd1);
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // rdata_q holds slot idx_q-1 once idx_q is past 0
          if (idx_q != '0 && take) begin
            best_q    <= prev_idx;
            beststr_q <= rdata_q.stride;
            found_q   <= 1'b1;
          end
          if (idx_q == AW'(NUM_SLOTS - 1)) state_q <= ST_SLAST;
          else idx_q <= idx_q + AW'(1);
        end
        ST_SLAST: begin
          // last slot is in rdata_q; it is recorded as idx_q, not through prev_idx
          if (rdata_q.queued && (!found_q || diff[31])) begin
            best_q    <= idx_q;
            beststr_q <= rdata_q.stride;
            found_q   <= 1'b1;
            state_q   <= ST_PRD;
          end else if (found_q) begin
            state_q <= ST_PRD;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_PRD: state_q <= ST_PLOAD;
        ST_PLOAD: begin
          pent_q <= rdata_q;
          pv_q   <= 1'b1;
          ps_q   <= 6'(best_q);
          quo_q  <= BIG_STEP;
          rem_q  <= '0;
          divs_q <= rdata_q.prio;
          dcnt_q <= '0;
          state_q <= (rdata_q.prio == 16'd0) ? ST_PWR : ST_DIV;
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          if (!rsub[16]) begin
            rem_q <= rsub[15:0];
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rtrial[15:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd31) state_q <= ST_PWR;
        end
        ST_PWR: state_q <= ST_OUT;
        ST_OUT: if (!res_stall_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign req_stall_o    = (state_q != ST_IDLE);
  assign res_valid_o    = (state_q == ST_OUT);
  assign picked_valid_o = pv_q;
  assign picked_slot_o  = ps_q;
  assign need_resched_o = rs_q;
  assign queued_count_o = 7'(count_q);

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= NUM_SLOTS)
    else $error("queued count out of range");
  a_one_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> req_stall_o)
    else $error("request taken while result pending");
  a_pick_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && picked_valid_o) |-> pent_q.queued)
    else $error("picked slot not queued");
`endif

endmodule

>>> dv/tb_stride_scheduler_core.sv
// testbench for the stride scheduler: directed table then random requests, checked by a predictor
module tb_stride_scheduler_core;
  import ss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic       vld;
    logic [5:0] slot;
    logic       resched;
    logic [6:0] count;
  } sched_res_t;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [15:0] prio;
    bit          typed;
    sched_res_t  res;
  } dir_row_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [7:0] cfg_wdata_i = 0;
  logic req_valid_i = 0, res_stall_i = 0;
  logic [1:0] req_type_i = 0;
  logic [5:0] slot_i = 0;
  logic [15:0] priority_req_i = 0;
  logic req_stall_o, res_valid_o, picked_valid_o, need_resched_o;
  logic [5:0] picked_slot_o;
  logic [6:0] queued_count_o;

  stride_scheduler_core DUT (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  logic [7:0]  max_slice;
  bit          on_queue [SLOTS];
  logic [31:0] stride_of [SLOTS];
  logic [15:0] prio_of [SLOTS];
  logic [7:0]  slice_of [SLOTS];
  logic [6:0]  n_queued;

  sched_res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit stall_mode = 1;

  function automatic sched_res_t schedule_step(logic [1:0] kind, logic [5:0] s,
                                               logic [15:0] p);
    sched_res_t r;
    int best;
    logic [31:0] diff;
    r = '0;
    case (kind)
      REQ_ENQ: if (!on_queue[s]) begin
        on_queue[s] = 1;
        prio_of[s] = p;
        if (slice_of[s] == 0 || slice_of[s] > max_slice) slice_of[s] = max_slice;
        n_queued++;
      end
      REQ_DEQ: if (on_queue[s]) begin
        on_queue[s] = 0;
        n_queued--;
      end
      REQ_PICK: begin
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!on_queue[i]) continue;
          if (best < 0) best = i;
          else begin
            diff = stride_of[i] - stride_of[best];
            if (diff[31]) best = i;
          end
        end
        if (best >= 0) begin
          stride_of[best] += (prio_of[best] == 0) ? BIG_STEP : BIG_STEP / prio_of[best];
          r.vld = 1;
          r.slot = best[5:0];
        end
      end
      default: begin
        if (slice_of[s] > 0) slice_of[s]--;
        r.resched = (slice_of[s] == 0);
      end
    endcase
    r.count = n_queued;
    return r;
  endfunction

  task automatic send_request(logic [1:0] kind, logic [5:0] s, logic [15:0] p);
    req_valid_i <= 1;
    req_type_i <= kind;
    slot_i <= s;
    priority_req_i <= p;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    pending_results.push_back(schedule_step(kind, s, p));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      req_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_valid_i <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_slice(logic [7:0] v);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    max_slice = v;
  endtask

  // result side: random stalls while stall_mode is set, a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_stall_i <= 1'b1;
    end else if (stall_mode)
      res_stall_i <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
    else
      res_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    sched_res_t got, want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      got = '{picked_valid_o, picked_slot_o, need_resched_o, queued_count_o};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  dir_row_t dir_rows[$];
  initial begin
    logic [1:0] k;
    logic [5:0] s;
    logic [7:0] slice_vals [5];
    max_slice = 5;
    for (int i = 0; i < SLOTS; i++) begin
      on_queue[i] = 0; stride_of[i] = 0; prio_of[i] = 0; slice_of[i] = 0;
    end
    n_queued = 0;
    slice_vals = '{8'd255, 8'd1, 8'd3, 8'd128, 8'd5};
    // directed rows; expected typed where obvious
    dir_rows = '{
      '{REQ_PICK, 6'd0, 16'd0, 1, '{1'b0, 6'd0, 1'b0, 7'd0}},
      '{REQ_TICK, 6'd63, 16'd0, 1, '{1'b0, 6'd0, 1'b1, 7'd0}},
      '{REQ_DEQ, 6'd5, 16'd0, 1, '{1'b0, 6'd0, 1'b0, 7'd0}},
      '{REQ_ENQ, 6'd63, 16'hFFFF, 1, '{1'b0, 6'd0, 1'b0, 7'd1}},
      '{REQ_ENQ, 6'd0, 16'd0, 1, '{1'b0, 6'd0, 1'b0, 7'd2}},
      '{REQ_ENQ, 6'd0, 16'd7, 1, '{1'b0, 6'd0, 1'b0, 7'd2}},
      '{REQ_PICK, 6'd0, 16'd0, 1, '{1'b1, 6'd0, 1'b0, 7'd2}},
      '{REQ_PICK, 6'd0, 16'd0, 1, '{1'b1, 6'd63, 1'b0, 7'd2}},
      '{REQ_PICK, 6'd0, 16'd0, 0, '0},
      '{REQ_PICK, 6'd0, 16'd0, 0, '0},
      '{REQ_PICK, 6'd0, 16'd0, 0, '0},
      '{REQ_ENQ, 6'd42, 16'd1, 0, '0},
      '{REQ_PICK, 6'd0, 16'd0, 0, '0},
      '{REQ_PICK, 6'd0, 16'd0, 0, '0},
      '{REQ_PICK, 6'd0, 16'd0, 0, '0},
      '{REQ_TICK, 6'd0, 16'd0, 0, '0},
      '{REQ_TICK, 6'd0, 16'd0, 0, '0},
      '{REQ_TICK, 6'd0, 16'd0, 0, '0},
      '{REQ_TICK, 6'd0, 16'd0, 0, '0},
      '{REQ_TICK, 6'd0, 16'd0, 0, '0},
      '{REQ_TICK, 6'd0, 16'd0, 0, '0},
      '{REQ_DEQ, 6'd0, 16'd0, 0, '0},
      '{REQ_ENQ, 6'd0, 16'h5555, 0, '0},
      '{REQ_DEQ, 6'd63, 16'hAAAA, 0, '0},
      '{REQ_PICK, 6'd0, 16'd0, 0, '0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].prio);
      if (dir_rows[i].typed && pending_results[$] !== dir_rows[i].res) begin
        errors++;
        if (errors <= 10)
          $display("row %0d table %p predictor %p", i, dir_rows[i].res, pending_results[$]);
      end
      idle_gap();
    end
    drain();

    // random phases across register settings, extremes first
    foreach (slice_vals[ph]) begin
      write_slice(slice_vals[ph]);
      if (ph == 1) hold_off = 400;  // receiver holds off while the sender waits on req_stall_o
      for (int n = 0; n < 165; n++) begin
        k = 2'($urandom_range(0, 3));
        // favor a narrow slot window so queue ops hit live slots
        s = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
        send_request(k, s, (k == REQ_ENQ && $urandom_range(0, 7) == 0) ? 16'd0 :
                             16'($urandom));
        if (ph == 4 && n == 80) begin
          stall_mode = 0;
          drain();
          stall_mode = 1;
        end else
          idle_gap();
      end
      drain();
    end

    if (errors == 0 && pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
